FILE: hdl/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types and constants for the rotation-matrix-to-quaternion block.
// ----------------------------------------------------------------------------
`default_nettype none

package rmq_pkg;

	localparam int WORD_BITS = 16;
	localparam int FRAC_BITS = 14;

	// element sums and differences
	localparam int SUM_W = WORD_BITS + 3;
	localparam int NUM_W = WORD_BITS + 1;
	localparam int R_W   = WORD_BITS + 2;

	// square root: S = floor(sqrt(r * 2^(FRAC_BITS+2)))
	localparam int PAIRS = (R_W + FRAC_BITS + 3) / 2;
	localparam int S_W   = PAIRS;
	localparam int X_W   = 2 * PAIRS;
	localparam int RM_W  = S_W + 2;

	// restoring divider
	localparam int CMP_W = S_W + WORD_BITS;

	// queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int QA_W    = 2;
	localparam int QC_W    = 3;

	localparam logic [1:0] BR_TRACE = 2'd0;
	localparam logic [1:0] BR_M00   = 2'd1;
	localparam logic [1:0] BR_M11   = 2'd2;
	localparam logic [1:0] BR_M22   = 2'd3;

	typedef struct packed {
		logic signed [WORD_BITS-1:0] m00;
		logic signed [WORD_BITS-1:0] m01;
		logic signed [WORD_BITS-1:0] m02;
		logic signed [WORD_BITS-1:0] m10;
		logic signed [WORD_BITS-1:0] m11;
		logic signed [WORD_BITS-1:0] m12;
		logic signed [WORD_BITS-1:0] m20;
		logic signed [WORD_BITS-1:0] m21;
		logic signed [WORD_BITS-1:0] m22;
	} rmq_mat_t;

	typedef struct packed {
		logic signed [WORD_BITS-1:0] q_w;
		logic signed [WORD_BITS-1:0] q_x;
		logic signed [WORD_BITS-1:0] q_y;
		logic signed [WORD_BITS-1:0] q_z;
		logic [1:0]                  branch_taken;
		logic                        invalid;
	} rmq_quat_t;

	// classified item handed from front to back
	typedef struct packed {
		logic [1:0]                 branch;
		logic                       invalid;
		logic [R_W-1:0]             rad;
		logic [3:0]                 neg;
		logic [3:0][NUM_W-1:0]      mag;
	} rmq_item_t;

endpackage

`default_nettype wire

FILE: hdl/rmq_front.sv
// ----------------------------------------------------------------------------
// rmq_front
// Accepts a matrix, picks the branch, forms the radicand and numerators.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_front (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  mat_valid,
	output logic                       mat_stall,
	input  wire rmq_pkg::rmq_mat_t     mat,
	input  wire logic [rmq_pkg::QC_W-1:0] q_level,
	output logic                       push,
	output rmq_pkg::rmq_item_t         push_item
);
	import rmq_pkg::*;

	logic              v_s1;
	rmq_item_t         item_s1;
	rmq_item_t         item_d;
	logic              take;

	// hold off while the queue could not absorb the item in flight plus a new one
	assign mat_stall = (QC_W'(q_level) + QC_W'(v_s1)) >= QC_W'(Q_DEPTH);
	assign take      = mat_valid && !mat_stall;

	// classify and form radicand and numerators
	always_comb begin
		logic signed [SUM_W-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
		logic signed [SUM_W-1:0] one, tr, rad;
		logic signed [SUM_W-1:0] n [4];
		a00 = SUM_W'(mat.m00); a01 = SUM_W'(mat.m01); a02 = SUM_W'(mat.m02);
		a10 = SUM_W'(mat.m10); a11 = SUM_W'(mat.m11); a12 = SUM_W'(mat.m12);
		a20 = SUM_W'(mat.m20); a21 = SUM_W'(mat.m21); a22 = SUM_W'(mat.m22);
		one = SUM_W'(1) <<< FRAC_BITS;
		tr  = a00 + a11 + a22;
		if (tr > 0) begin
			item_d.branch = BR_TRACE;
			rad  = one + tr;
			n[0] = '0;        n[1] = a21 - a12;
			n[2] = a02 - a20; n[3] = a10 - a01;
		end else if (a00 > a11 && a00 > a22) begin
			item_d.branch = BR_M00;
			rad  = one + a00 - a11 - a22;
			n[0] = a21 - a12; n[1] = '0;
			n[2] = a01 + a10; n[3] = a02 + a20;
		end else if (a11 > a22) begin
			item_d.branch = BR_M11;
			rad  = one + a11 - a00 - a22;
			n[0] = a02 - a20; n[1] = a01 + a10;
			n[2] = '0;        n[3] = a12 + a21;
		end else begin
			item_d.branch = BR_M22;
			rad  = one + a22 - a00 - a11;
			n[0] = a10 - a01; n[1] = a02 + a20;
			n[2] = a12 + a21; n[3] = '0;
		end
		item_d.invalid = (rad <= 0);
		item_d.rad     = R_W'(rad);
		for (int j = 0; j < 4; j++) begin
			item_d.neg[j] = n[j][SUM_W-1];
			item_d.mag[j] = n[j][SUM_W-1] ? NUM_W'(-n[j]) : NUM_W'(n[j]);
		end
	end

	// register the classified item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item_d;
		end
	end

	assign push      = v_s1;
	assign push_item = item_s1;

endmodule

`default_nettype wire

FILE: hdl/rmq_queue.sv
// ----------------------------------------------------------------------------
// rmq_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_queue (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     push,
	input  wire rmq_pkg::rmq_item_t       push_item,
	input  wire logic                     pop,
	output logic                          head_valid,
	output rmq_pkg::rmq_item_t            head_item,
	output logic [rmq_pkg::QC_W-1:0]      level
);
	import rmq_pkg::*;

	rmq_item_t         mem_q [Q_DEPTH];
	logic [QA_W-1:0]   wr_q, rd_q;
	logic [QC_W-1:0]   cnt_q;
	logic              do_pop;

	assign do_pop     = pop && (cnt_q != '0);
	assign head_valid = (cnt_q != '0);
	assign head_item  = mem_q[rd_q];
	assign level      = cnt_q;

	// advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QA_W'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + QA_W'(1);
			end
			cnt_q <= cnt_q + QC_W'(push) - QC_W'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/rmq_back.sv
// ----------------------------------------------------------------------------
// rmq_back
// Pipelined square root, four restoring dividers and output saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                head_valid,
	input  wire rmq_pkg::rmq_item_t  head_item,
	output logic                     pop,
	output logic                     quat_valid,
	input  wire logic                quat_stall,
	output rmq_pkg::rmq_quat_t       quat
);
	import rmq_pkg::*;

	logic en;

	// root stages
	logic              sq_v_s   [PAIRS];
	rmq_item_t         sq_it_s  [PAIRS];
	logic [RM_W-1:0]   sq_rem_s [PAIRS];
	logic [S_W-1:0]    sq_root_s[PAIRS];

	// divider stages: index 0 is the setup stage, then one per quotient bit
	logic                         dv_v_s   [WORD_BITS+1];
	logic [1:0]                   dv_br_s  [WORD_BITS+1];
	logic                         dv_inv_s [WORD_BITS+1];
	logic [3:0]                   dv_neg_s [WORD_BITS+1];
	logic [3:0]                   dv_ovf_s [WORD_BITS+1];
	logic [S_W-1:0]               dv_s_s   [WORD_BITS+1];
	logic [3:0][CMP_W-1:0]        dv_rem_s [WORD_BITS+1];
	logic [3:0][WORD_BITS-1:0]    dv_quo_s [WORD_BITS+1];

	logic      out_v_q;
	rmq_quat_t out_q;
	rmq_quat_t quat_d;

	// the whole back end moves unless a finished result is held
	assign en         = !(out_v_q && quat_stall);
	assign pop        = head_valid && en;
	assign quat_valid = out_v_q;
	assign quat       = out_q;

	// one root bit per stage
	for (genvar k = 0; k < PAIRS; k++) begin : g_sq
		logic              pv;
		rmq_item_t         pit;
		logic [RM_W-1:0]   prem;
		logic [S_W-1:0]    proot;
		logic [X_W-1:0]    xv;
		logic [1:0]        two;
		logic [RM_W+1:0]   rsh, trial;
		logic              ge;
		if (k == 0) begin : g_first
			assign pv    = pop;
			assign pit   = head_item;
			assign prem  = '0;
			assign proot = '0;
		end else begin : g_next
			assign pv    = sq_v_s[k-1];
			assign pit   = sq_it_s[k-1];
			assign prem  = sq_rem_s[k-1];
			assign proot = sq_root_s[k-1];
		end
		assign xv    = X_W'({pit.rad, {(FRAC_BITS+2){1'b0}}});
		assign two   = xv[2*(PAIRS-1-k) +: 2];
		assign rsh   = {prem, two};
		assign trial = (RM_W+2)'({proot, 2'b01});
		assign ge    = rsh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[k] <= 1'b0;
			end else if (en) begin
				sq_v_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_it_s[k]   <= pit;
				sq_rem_s[k]  <= ge ? RM_W'(rsh - trial) : RM_W'(rsh);
				sq_root_s[k] <= {proot[S_W-2:0], ge};
			end
		end
	end

	// divider setup: dividend with rounding term, overflow check
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s[0] <= 1'b0;
		end else if (en) begin
			dv_v_s[0] <= sq_v_s[PAIRS-1];
		end
	end

	always_ff @(posedge clk) begin
		logic [CMP_W-1:0] dd;
		logic [S_W-1:0]   sv;
		if (en) begin
			sv = sq_root_s[PAIRS-1];
			dv_br_s[0]  <= sq_it_s[PAIRS-1].branch;
			dv_inv_s[0] <= sq_it_s[PAIRS-1].invalid;
			dv_neg_s[0] <= sq_it_s[PAIRS-1].neg;
			dv_s_s[0]   <= sv;
			for (int j = 0; j < 4; j++) begin
				dd = (CMP_W'(sq_it_s[PAIRS-1].mag[j]) << FRAC_BITS) + CMP_W'(sv >> 1);
				dv_rem_s[0][j] <= dd;
				dv_ovf_s[0][j] <= dd >= (CMP_W'(sv) << WORD_BITS);
				dv_quo_s[0][j] <= '0;
			end
		end
	end

	// one quotient bit per stage, all four lanes side by side
	for (genvar st = 1; st <= WORD_BITS; st++) begin : g_dv
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[st] <= 1'b0;
			end else if (en) begin
				dv_v_s[st] <= dv_v_s[st-1];
			end
		end

		always_ff @(posedge clk) begin
			logic [CMP_W-1:0] sh;
			logic             ge;
			if (en) begin
				dv_br_s[st]  <= dv_br_s[st-1];
				dv_inv_s[st] <= dv_inv_s[st-1];
				dv_neg_s[st] <= dv_neg_s[st-1];
				dv_ovf_s[st] <= dv_ovf_s[st-1];
				dv_s_s[st]   <= dv_s_s[st-1];
				sh = CMP_W'(dv_s_s[st-1]) << (WORD_BITS - st);
				for (int j = 0; j < 4; j++) begin
					ge = dv_rem_s[st-1][j] >= sh;
					dv_rem_s[st][j] <= ge ? dv_rem_s[st-1][j] - sh : dv_rem_s[st-1][j];
					dv_quo_s[st][j] <= {dv_quo_s[st-1][j][WORD_BITS-2:0], ge};
				end
			end
		end
	end

	// saturate, place the diagonal term, zero invalid results
	always_comb begin
		logic signed [WORD_BITS-1:0] res [4];
		logic [WORD_BITS-1:0]        qv;
		logic                        big;
		logic [S_W-1:0]              dg;
		logic [S_W-1:0]              lim;
		lim = S_W'({1'b0, {(WORD_BITS-1){1'b1}}});
		dg  = dv_s_s[WORD_BITS] >> 2;
		for (int j = 0; j < 4; j++) begin
			qv  = dv_quo_s[WORD_BITS][j];
			big = dv_ovf_s[WORD_BITS][j] || qv[WORD_BITS-1];
			if (dv_inv_s[WORD_BITS]) begin
				res[j] = '0;
			end else if (dv_br_s[WORD_BITS] == 2'(j)) begin
				res[j] = (dg > lim) ? WORD_BITS'(lim) : WORD_BITS'(dg);
			end else if (dv_neg_s[WORD_BITS][j]) begin
				res[j] = big ? {1'b1, {(WORD_BITS-1){1'b0}}} : -$signed(qv);
			end else begin
				res[j] = big ? {1'b0, {(WORD_BITS-1){1'b1}}} : $signed(qv);
			end
		end
		quat_d.q_w          = res[0];
		quat_d.q_x          = res[1];
		quat_d.q_y          = res[2];
		quat_d.q_z          = res[3];
		quat_d.branch_taken = dv_br_s[WORD_BITS];
		quat_d.invalid      = dv_inv_s[WORD_BITS];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= dv_v_s[WORD_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= quat_d;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/rotation_matrix_to_quaternion_top.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_top
// Rotation matrix (Q2.14) to unit quaternion, four-branch method.
// ----------------------------------------------------------------------------
// Takes one matrix per cycle and returns one quaternion per cycle, in order,
// unless mat_stall or quat_stall holds the flow. From the matrix transfer to
// the quaternion transfer an item passes the front register, the queue slot,
// the 17-stage bit-per-stage square root, a divider setup stage, the 16-stage
// restoring dividers that run four lanes side by side, and the output
// register. The front registers the branch choice and numerators and
// feeds a four-entry queue, so a stalled result freezes only the back end
// while the front keeps taking matrices until the queue fills. A non-positive
// radicand yields zero components with invalid set.
`default_nettype none

module rotation_matrix_to_quaternion_top (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                mat_valid,
	output logic                     mat_stall,
	input  wire rmq_pkg::rmq_mat_t   mat,
	output logic                     quat_valid,
	input  wire logic                quat_stall,
	output rmq_pkg::rmq_quat_t       quat
);
	import rmq_pkg::*;

	logic              push, pop, head_valid;
	rmq_item_t         push_item, head_item;
	logic [QC_W-1:0]   level;

	rmq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.mat_valid (mat_valid),
		.mat_stall (mat_stall),
		.mat       (mat),
		.q_level   (level),
		.push      (push),
		.push_item (push_item)
	);

	rmq_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item),
		.level      (level)
	);

	rmq_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop),
		.quat_valid (quat_valid),
		.quat_stall (quat_stall),
		.quat       (quat)
	);

endmodule

`default_nettype wire
